// ===== design/acp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm command parser package
// Shared types and constants: command codes, action codes, the ASCII
// characters of the command syntax and the threshold limits.
// ----------------------------------------------------------------------------
package acp_pkg;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_EXEC   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Only the first bytes of the buffer are ever parsed.
    localparam int PARSE_BYTES = 10;

    // Width of the signed digit sum: covers -48*1111 .. 207*1111.
    localparam int SUM_W = 19;

    localparam logic [9:0] THRESH_MAX = 10'd1000;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_SLASH = "/";
    localparam logic [7:0] CHAR_A     = "A";
    localparam logic [7:0] CHAR_L     = "L";
    localparam logic [7:0] CHAR_M     = "M";
    localparam logic [7:0] CHAR_H     = "H";
    localparam logic [7:0] CHAR_ONE   = "1";
    localparam logic [7:0] CHAR_TWO   = "2";

    localparam logic [23:0] TAIL_PTB = "PTB";
    localparam logic [23:0] TAIL_ING = "ING";
    localparam logic [23:0] TAIL_GER = "GER";

    localparam logic [1:0] LANG_PTB = 2'd0;
    localparam logic [1:0] LANG_ING = 2'd1;
    localparam logic [1:0] LANG_GER = 2'd2;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_LANG  = 2'd1,
        ACT_ALARM = 2'd2
    } action_t;

    // The parsed head of the command buffer, byte 0 in the lowest lane.
    typedef logic [PARSE_BYTES-1:0][7:0] bytes_t;

    typedef struct packed {
        logic [9:0] ch2_high;
        logic [9:0] ch2_low;
        logic [9:0] ch1_high;
        logic [9:0] ch1_low;
    } thresh_t;

    typedef struct packed {
        action_t    action;
        logic [1:0] lang;
        thresh_t    thr;
    } result_t;

endpackage

// ===== design/alarm_command_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm command parser
// Collects command bytes and executes language and alarm threshold commands.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on the s_axis channel carries a command in tuser
// (append, execute or clear) and a character in tdata. Appends write the
// character at a pointer that wraps after BUFFER_DEPTH bytes; clear refills
// the buffer with ASCII zero and rewinds the pointer; execute parses the
// buffer for a language or an alarm threshold command.
// Every input transaction yields exactly one output transaction on m_axis
// holding the four thresholds, the language and the action after the step.
// The input register captures each accepted transaction, then the parser and
// state update feed the output register. A new transaction is accepted every
// cycle while the output register can take a result.
// When the receiver stalls, the output register holds its transaction and
// the input register holds one more; s_axis_tready drops only when both
// are full. Reset empties both registers, fills the buffer with ASCII zero,
// sets low thresholds to 0, high thresholds to 1000 and language to 0.
// ----------------------------------------------------------------------------
module alarm_command_parser
#(
    parameter int BUFFER_DEPTH = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_in[7:0]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // ch1_low, ch1_high, ch2_low, ch2_high,
                                        // lang_sel, action, zero padding
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);

    logic                 s1_valid_reg;
    logic [1:0]           s1_cmd_reg;
    logic [7:0]           s1_char_reg;
    logic                 s1_fire;

    acp_pkg::bytes_t      bytes_reg;
    acp_pkg::bytes_t      bytes_next;
    logic [PTR_W-1:0]     ptr_reg;
    logic [PTR_W-1:0]     ptr_next;
    acp_pkg::thresh_t     thr_reg;
    logic [1:0]           lang_reg;

    acp_pkg::result_t     result;
    logic                 out_valid_reg;
    acp_pkg::result_t     out_data_reg;

    // Input register advances whenever the output register can take a result.
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_cmd_reg  <= s_axis_tuser;
            s1_char_reg <= s_axis_tdata;
        end
    end

    // Execute decoding and threshold update.
    acp_parser u_parser
    (
        .do_exec   (s1_cmd_reg == acp_pkg::CMD_EXEC),
        .buf_bytes (bytes_reg),
        .thr_cur   (thr_reg),
        .lang_cur  (lang_reg),
        .result    (result)
    );

    // Buffer and pointer update; bytes past the parsed head are never read.
    always_comb
    begin
        bytes_next = bytes_reg;
        ptr_next   = ptr_reg;
        if (s1_fire)
        begin
            case (s1_cmd_reg)
                acp_pkg::CMD_APPEND:
                begin
                    for (int i = 0; i < acp_pkg::PARSE_BYTES; i++)
                    begin
                        if (ptr_reg == PTR_W'(i))
                        begin
                            bytes_next[i] = s1_char_reg;
                        end
                    end
                    ptr_next = (ptr_reg == PTR_W'(BUFFER_DEPTH - 1)) ?
                               '0 : ptr_reg + 1'b1;
                end
                acp_pkg::CMD_CLEAR:
                begin
                    bytes_next = {acp_pkg::PARSE_BYTES{acp_pkg::CHAR_ZERO}};
                    ptr_next   = '0;
                end
                default:
                begin
                    bytes_next = bytes_reg;
                    ptr_next   = ptr_reg;
                end
            endcase
        end
    end

    // Block state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg        <= {acp_pkg::PARSE_BYTES{acp_pkg::CHAR_ZERO}};
            ptr_reg          <= '0;
            thr_reg.ch1_low  <= '0;
            thr_reg.ch1_high <= acp_pkg::THRESH_MAX;
            thr_reg.ch2_low  <= '0;
            thr_reg.ch2_high <= acp_pkg::THRESH_MAX;
            lang_reg         <= acp_pkg::LANG_PTB;
        end
        else
        begin
            bytes_reg <= bytes_next;
            ptr_reg   <= ptr_next;
            if (s1_fire)
            begin
                thr_reg  <= result.thr;
                lang_reg <= result.lang;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_data_reg};

    // Checks on the block's own invariants.
    a_ch1_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[9:0] < m_axis_tdata[19:10]))
        else $error("channel one low threshold not below high threshold");

    a_ch2_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[29:20] < m_axis_tdata[39:30]))
        else $error("channel two low threshold not below high threshold");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(BUFFER_DEPTH - 1))
        else $error("write pointer beyond buffer depth");

    a_lang_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (result.action != acp_pkg::ACT_LANG)) |=>
        (lang_reg == $past(lang_reg)))
        else $error("language changed without a language command");

endmodule

// ===== design/acp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm command parser: execute decoder
// Decodes the language and alarm commands held in the head of the buffer
// and works out the thresholds, language and action after an execute.
// ----------------------------------------------------------------------------
module acp_parser
(
    input  logic            do_exec,
    input  acp_pkg::bytes_t buf_bytes,
    input  acp_pkg::thresh_t thr_cur,
    input  logic [1:0]      lang_cur,
    output acp_pkg::result_t result
);

    logic [23:0]                    lang_tail;
    logic                           lang_cmd;
    logic                           alarm_cmd;
    logic                           ch_one;
    logic                           ch_two;
    logic signed [acp_pkg::SUM_W-1:0] digit [4];
    logic signed [acp_pkg::SUM_W-1:0] sum;
    logic [9:0]                     value;

    // Language tail sits in bytes 2 to 4, first character highest.
    assign lang_tail = {buf_bytes[2], buf_bytes[3], buf_bytes[4]};
    assign lang_cmd  = (buf_bytes[1] == acp_pkg::CHAR_L);
    assign alarm_cmd = (buf_bytes[0] == acp_pkg::CHAR_SLASH) &&
                       (buf_bytes[1] == acp_pkg::CHAR_A) &&
                       (buf_bytes[2] == acp_pkg::CHAR_L) &&
                       (buf_bytes[3] == acp_pkg::CHAR_M);
    assign ch_one    = (buf_bytes[4] == acp_pkg::CHAR_ONE);
    assign ch_two    = (buf_bytes[4] == acp_pkg::CHAR_TWO);

    // Digits are taken as unsigned bytes less ASCII zero, so may be negative.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            digit[i] = $signed({{(acp_pkg::SUM_W-8){1'b0}}, buf_bytes[6+i]})
                       - $signed(acp_pkg::SUM_W'(acp_pkg::CHAR_ZERO));
        end
    end

    // Constant-weight sum, then clipped to the threshold range.
    assign sum = digit[0] * $signed(acp_pkg::SUM_W'(1000))
               + digit[1] * $signed(acp_pkg::SUM_W'(100))
               + digit[2] * $signed(acp_pkg::SUM_W'(10))
               + digit[3];

    always_comb
    begin
        if (sum < 0)
        begin
            value = '0;
        end
        else if (sum > $signed(acp_pkg::SUM_W'(acp_pkg::THRESH_MAX)))
        begin
            value = acp_pkg::THRESH_MAX;
        end
        else
        begin
            value = sum[9:0];
        end
    end

    // Apply the decoded command; a rejected value keeps the old threshold.
    always_comb
    begin
        result.thr    = thr_cur;
        result.lang   = lang_cur;
        result.action = acp_pkg::ACT_NONE;
        if (do_exec)
        begin
            if (lang_cmd)
            begin
                if (lang_tail == acp_pkg::TAIL_PTB)
                begin
                    result.lang   = acp_pkg::LANG_PTB;
                    result.action = acp_pkg::ACT_LANG;
                end
                else if (lang_tail == acp_pkg::TAIL_ING)
                begin
                    result.lang   = acp_pkg::LANG_ING;
                    result.action = acp_pkg::ACT_LANG;
                end
                else if (lang_tail == acp_pkg::TAIL_GER)
                begin
                    result.lang   = acp_pkg::LANG_GER;
                    result.action = acp_pkg::ACT_LANG;
                end
            end
            if (alarm_cmd && (ch_one || ch_two))
            begin
                if (buf_bytes[5] == acp_pkg::CHAR_H)
                begin
                    result.action = acp_pkg::ACT_ALARM;
                    if (ch_one && (value > thr_cur.ch1_low))
                    begin
                        result.thr.ch1_high = value;
                    end
                    if (ch_two && (value > thr_cur.ch2_low))
                    begin
                        result.thr.ch2_high = value;
                    end
                end
                else if (buf_bytes[5] == acp_pkg::CHAR_L)
                begin
                    result.action = acp_pkg::ACT_ALARM;
                    if (ch_one && (value < thr_cur.ch1_high))
                    begin
                        result.thr.ch1_low = value;
                    end
                    if (ch_two && (value < thr_cur.ch2_high))
                    begin
                        result.thr.ch2_low = value;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/alarm_command_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm command parser testbench
// Drives command transactions into the parser and checks every status
// transaction against a shadow model of the buffer, thresholds and language.
// A short table of hand-picked commands runs first, then randomised command
// lines, with bursty input, a stalling receiver and one long output hold-off.
// ----------------------------------------------------------------------------
module alarm_command_parser_tb;

    localparam int         BUFFER_DEPTH = 15;
    localparam int         ITEM_COUNT   = 1250;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         HOLD_CYCLES  = 300;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // One row of the directed table: an optional text appended byte by byte,
    // then a repeated command, whose status may be given by hand.
    typedef struct {
        logic [1:0]       cmd;
        string            text;
        logic [7:0]       fill;
        int               reps;
        bit               typed;
        acp_pkg::result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // char_in[7:0]
    logic [1:0]  s_axis_tuser = '0;     // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // ch1_low, ch1_high, ch2_low, ch2_high,
                                        // lang_sel, action, zero padding

    // Shadow copy of the parser state.
    logic [7:0] shadow_buf [BUFFER_DEPTH];
    int         shadow_pos;
    logic [9:0] low_thr [2];
    logic [9:0] high_thr [2];
    logic [1:0] lang_q;

    acp_pkg::result_t expected_status [$];
    stim_row_t        stim_table [$];

    int mismatches    = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int lang_hits     = 0;
    int alarm_hits    = 0;
    int burst_left    = 0;
    int cycle_count   = 0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int rx_run        = 0;

    alarm_command_parser #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic acp_pkg::result_t status(int l1, int h1, int l2, int h2,
                                                logic [1:0] lang,
                                                acp_pkg::action_t act);
        acp_pkg::result_t r;
        r.thr.ch1_low  = l1[9:0];
        r.thr.ch1_high = h1[9:0];
        r.thr.ch2_low  = l2[9:0];
        r.thr.ch2_high = h2[9:0];
        r.lang         = lang;
        r.action       = act;
        return r;
    endfunction

    function automatic void clear_shadow();
        foreach (shadow_buf[i])
            shadow_buf[i] = acp_pkg::CHAR_ZERO;
        shadow_pos = 0;
    endfunction

    // Applies one command to the shadow state and returns the status after it.
    function automatic acp_pkg::result_t apply_command(logic [1:0] cmd, logic [7:0] ch);
        acp_pkg::action_t act;
        int      v;
        int      c;
        act = acp_pkg::ACT_NONE;
        case (cmd)
            acp_pkg::CMD_APPEND:
            begin
                if (shadow_pos >= BUFFER_DEPTH)
                    shadow_pos = 0;
                shadow_buf[shadow_pos] = ch;
                shadow_pos++;
            end
            acp_pkg::CMD_EXEC:
            begin
                // Language: byte 1 is 'L' and bytes 2 to 4 name the language.
                if (shadow_buf[1] == acp_pkg::CHAR_L)
                begin
                    if ({shadow_buf[2], shadow_buf[3], shadow_buf[4]} == acp_pkg::TAIL_PTB)
                    begin
                        lang_q = acp_pkg::LANG_PTB;
                        act    = acp_pkg::ACT_LANG;
                    end
                    else if ({shadow_buf[2], shadow_buf[3], shadow_buf[4]} ==
                             acp_pkg::TAIL_ING)
                    begin
                        lang_q = acp_pkg::LANG_ING;
                        act    = acp_pkg::ACT_LANG;
                    end
                    else if ({shadow_buf[2], shadow_buf[3], shadow_buf[4]} ==
                             acp_pkg::TAIL_GER)
                    begin
                        lang_q = acp_pkg::LANG_GER;
                        act    = acp_pkg::ACT_LANG;
                    end
                end
                // Alarm: "/ALM", channel, level, then four digits.
                if (shadow_buf[0] == acp_pkg::CHAR_SLASH && shadow_buf[1] == acp_pkg::CHAR_A &&
                    shadow_buf[2] == acp_pkg::CHAR_L && shadow_buf[3] == acp_pkg::CHAR_M &&
                    (shadow_buf[4] == acp_pkg::CHAR_ONE ||
                     shadow_buf[4] == acp_pkg::CHAR_TWO))
                begin
                    c = (shadow_buf[4] == acp_pkg::CHAR_ONE) ? 0 : 1;
                    v = (int'(shadow_buf[6]) - int'(acp_pkg::CHAR_ZERO)) * 1000 +
                        (int'(shadow_buf[7]) - int'(acp_pkg::CHAR_ZERO)) * 100 +
                        (int'(shadow_buf[8]) - int'(acp_pkg::CHAR_ZERO)) * 10 +
                        (int'(shadow_buf[9]) - int'(acp_pkg::CHAR_ZERO));
                    if (v < 0)
                        v = 0;
                    if (v > int'(acp_pkg::THRESH_MAX))
                        v = int'(acp_pkg::THRESH_MAX);
                    if (shadow_buf[5] == acp_pkg::CHAR_H)
                    begin
                        if (v > int'(low_thr[c]))
                            high_thr[c] = v[9:0];
                        act = acp_pkg::ACT_ALARM;
                    end
                    else if (shadow_buf[5] == acp_pkg::CHAR_L)
                    begin
                        if (v < int'(high_thr[c]))
                            low_thr[c] = v[9:0];
                        act = acp_pkg::ACT_ALARM;
                    end
                end
            end
            acp_pkg::CMD_CLEAR:
                clear_shadow();
            default:
                ;
        endcase
        return status(low_thr[0], high_thr[0], low_thr[1], high_thr[1], lang_q, act);
    endfunction

    // Offers one input transaction, with the burst and gap pattern of the
    // sender, and records the expected status once it is accepted.
    task automatic offer_item(logic [1:0] cmd, logic [7:0] ch, bit typed,
                              acp_pkg::result_t want);
        acp_pkg::result_t pred;
        int      gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 16);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = apply_command(cmd, ch);
        expected_status.push_back(typed ? want : pred);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic append_bytes(logic [7:0] text [$]);
        foreach (text[i])
            offer_item(acp_pkg::CMD_APPEND, text[i], 1'b0, '0);
    endtask

    // Stops offering and waits until every expected status has arrived.
    task automatic drain_outputs();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(logic [1:0] cmd, string text, logic [7:0] fill, int reps,
                           bit typed, acp_pkg::result_t want);
        stim_row_t row;
        row.cmd   = cmd;
        row.text  = text;
        row.fill  = fill;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        stim_table.push_back(row);
    endtask

    // Four digit bytes for an alarm value: mostly in range, some beyond the
    // clip limit, some arbitrary bytes that are no digits at all.
    task automatic make_digits(ref logic [7:0] text [$]);
        int v;
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            v = (r < 70) ? $urandom_range(0, 1000) : $urandom_range(1001, 9999);
            text.push_back(acp_pkg::CHAR_ZERO + 8'((v / 1000) % 10));
            text.push_back(acp_pkg::CHAR_ZERO + 8'((v / 100) % 10));
            text.push_back(acp_pkg::CHAR_ZERO + 8'((v / 10) % 10));
            text.push_back(acp_pkg::CHAR_ZERO + 8'(v % 10));
        end
        else
        begin
            repeat (4)
                text.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // One random command line: usually a clean buffer, a well-formed
    // language or alarm command, and an execute; sometimes noise.
    task automatic random_command();
        logic [7:0] text [$];
        logic [23:0] tail;
        int kind;
        int r;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 9) != 0)
            offer_item(acp_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
        if (kind < 25)
        begin
            r = $urandom_range(0, 2);
            tail = (r == 0) ? acp_pkg::TAIL_PTB : (r == 1) ? acp_pkg::TAIL_ING
                                                           : acp_pkg::TAIL_GER;
            text = {8'($urandom_range(0, 255)), acp_pkg::CHAR_L,
                    tail[23:16], tail[15:8], tail[7:0]};
        end
        else if (kind < 85)
        begin
            text = {acp_pkg::CHAR_SLASH, acp_pkg::CHAR_A, acp_pkg::CHAR_L, acp_pkg::CHAR_M};
            r = $urandom_range(0, 99);
            text.push_back((r < 45) ? acp_pkg::CHAR_ONE : (r < 90) ? acp_pkg::CHAR_TWO
                                    : 8'($urandom_range(0, 255)));
            r = $urandom_range(0, 99);
            text.push_back((r < 45) ? acp_pkg::CHAR_H : (r < 90) ? acp_pkg::CHAR_L
                                    : 8'($urandom_range(0, 255)));
            make_digits(text);
        end
        else
        begin
            repeat ($urandom_range(0, 20))
                text.push_back(8'($urandom_range(0, 255)));
        end
        // Corrupt one byte now and then.
        if ($urandom_range(0, 9) == 0 && text.size() > 0)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
        append_bytes(text);
        offer_item(acp_pkg::CMD_EXEC, 8'($urandom_range(0, 255)), 1'b0, '0);
        if ($urandom_range(0, 19) == 0)
            offer_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'b0, '0);
        if ($urandom_range(0, 19) == 0)
            offer_item(acp_pkg::CMD_EXEC, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic check_field(string name, int want, int seen);
        if (want != seen)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
        end
    endtask

    // Output side: compare each accepted status with the oldest expectation.
    always @(posedge clk)
    begin : status_check
        acp_pkg::result_t seen;
        acp_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = acp_pkg::result_t'(m_axis_tdata[$bits(acp_pkg::result_t)-1:0]);
            if (expected_status.size() == 0)
            begin
                $error("Status transaction arrived with none expected");
                mismatches++;
            end
            else
            begin
                want = expected_status.pop_front();
                results_seen++;
                if (want.action == acp_pkg::ACT_LANG)
                    lang_hits++;
                if (want.action == acp_pkg::ACT_ALARM)
                    alarm_hits++;
                check_field("ch1_low",  want.thr.ch1_low,  seen.thr.ch1_low);
                check_field("ch1_high", want.thr.ch1_high, seen.thr.ch1_high);
                check_field("ch2_low",  want.thr.ch2_low,  seen.thr.ch2_low);
                check_field("ch2_high", want.thr.ch2_high, seen.thr.ch2_high);
                check_field("lang_sel", want.lang,         seen.lang);
                check_field("action",   want.action,       seen.action);
            end
        end
    end

    // Receiver: runs of ready and short stalls, with a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else if (rx_run > 0)
        begin
            rx_run--;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            m_axis_tready <= 1'b0;
            rx_run = $urandom_range(0, 4);
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(0, 30);
        end
    end

    initial
    begin
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;

        clear_shadow();
        low_thr  = '{10'd0, 10'd0};
        high_thr = '{acp_pkg::THRESH_MAX, acp_pkg::THRESH_MAX};
        lang_q   = acp_pkg::LANG_PTB;

        // Directed commands; the thresholds stay at their reset values here.
        add_row(acp_pkg::CMD_EXEC, "", 8'h00, 1, 1'b1,
                status(0, 1000, 0, 1000, acp_pkg::LANG_PTB, acp_pkg::ACT_NONE));
        add_row(CMD_UNUSED, "", 8'hFF, 1, 1'b1,
                status(0, 1000, 0, 1000, acp_pkg::LANG_PTB, acp_pkg::ACT_NONE));
        add_row(acp_pkg::CMD_APPEND, "/LGER", 8'h00, 0, 1'b0, '0);
        add_row(acp_pkg::CMD_EXEC, "", 8'hFF, 1, 1'b1,
                status(0, 1000, 0, 1000, acp_pkg::LANG_GER, acp_pkg::ACT_LANG));
        add_row(acp_pkg::CMD_CLEAR, "", 8'h00, 1, 1'b1,
                status(0, 1000, 0, 1000, acp_pkg::LANG_GER, acp_pkg::ACT_NONE));
        // Digits still read zero: a high of 0 is not above the low of 0.
        add_row(acp_pkg::CMD_APPEND, "/ALM2H", 8'h00, 0, 1'b0, '0);
        add_row(acp_pkg::CMD_EXEC, "", 8'h00, 1, 1'b1,
                status(0, 1000, 0, 1000, acp_pkg::LANG_GER, acp_pkg::ACT_ALARM));
        // Digit bytes at the top of the byte range clip to 1000.
        add_row(acp_pkg::CMD_APPEND, "", 8'hFF, 4, 1'b0, '0);
        add_row(acp_pkg::CMD_EXEC, "", 8'h00, 1, 1'b1,
                status(0, 1000, 0, 1000, acp_pkg::LANG_GER, acp_pkg::ACT_ALARM));
        // Fill the rest of the buffer, then wrap to byte 0 with a bad channel.
        add_row(acp_pkg::CMD_APPEND, "", 8'h00, 5, 1'b0, '0);
        add_row(acp_pkg::CMD_APPEND, "/ALM3", 8'h00, 0, 1'b0, '0);
        add_row(acp_pkg::CMD_EXEC, "", 8'hFF, 1, 1'b1,
                status(0, 1000, 0, 1000, acp_pkg::LANG_GER, acp_pkg::ACT_NONE));

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            for (int k = 0; k < stim_table[i].text.len(); k++)
                offer_item(acp_pkg::CMD_APPEND, stim_table[i].text[k], 1'b0, '0);
            repeat (stim_table[i].reps)
                offer_item(stim_table[i].cmd, stim_table[i].fill,
                           stim_table[i].typed, stim_table[i].want);
        end

        // Random command lines, with one long receiver hold-off and one pause.
        while (items_sent < ITEM_COUNT)
        begin
            if (!held && items_sent > 400)
            begin
                held = 1'b1;
                hold_request = 1'b1;
            end
            if (!paused && items_sent > 800)
            begin
                paused = 1'b1;
                drain_outputs();
            end
            random_command();
        end

        drain_outputs();
        repeat (10)
            @(posedge clk);

        $display("Ran %0d command transactions and checked %0d status transactions,",
                 items_sent, results_seen);
        $display("%0d recognised as language and %0d as alarm commands.",
                 lang_hits, alarm_hits);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
